[src/bmpd_pkg.sv]
// Shared types and constants of the 24-bit BMP stream decoder.
// No dependencies; imported by bmpd_parse, bmpd_out_fifo, the top level and the checker.
package bmpd_pkg;

    // Image size limits, defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration register map and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_MIN  = 1'd1;
    localparam logic [7:0] CORE_MIN_RST = 8'd12;
    localparam logic [7:0] EXT_MIN_RST  = 8'd40;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_MAGIC      = 3'd1,
        ERR_HEADER     = 3'd2,
        ERR_COMPRESSED = 3'd3,
        ERR_RANGE      = 3'd4
    } t_err_code;

    // One result word
    typedef struct packed {
        logic        kind;
        t_err_code   error_code;
        logic [7:0]  first_color;
        logic [7:0]  second_color;
        logic [7:0]  third_color;
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic        last_pixel;
    } t_result;

endpackage

[src/bmpd_in_reg.sv]
// Input register stage of the BMP stream decoder.
// Depends on nothing but the clock and reset; feeds bmpd_parse.
module bmpd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    input  logic       i_down_ready,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_start_of_file
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_start;

    // Take a new word when empty or when the held word moves on
    assign o_ready = !r_valid || i_down_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data_byte <= i_data_byte;
            r_start     <= i_start_of_file;
        end
    end

    assign o_valid         = r_valid;
    assign o_data_byte     = r_data_byte;
    assign o_start_of_file = r_start;

endmodule

[src/bmpd_parse.sv]
// Header parser, offset skipper and pixel assembler of the BMP stream decoder.
// Depends on bmpd_pkg; consumes one byte per fire and emits at most one result.
module bmpd_parse
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    input  logic [7:0] i_core_min,
    input  logic [7:0] i_ext_min,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Last byte positions of the header fields
    localparam logic [31:0] POS_MAGIC  = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_INFO   = 32'd17;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_BPP    = 32'd29;
    localparam logic [31:0] POS_COMP   = 32'd33;
    localparam logic [31:0] POS_END    = 32'd53;
    localparam logic [5:0]  HDR_END_CORE = 6'd30;
    localparam logic [5:0]  HDR_END_EXT  = 6'd54;
    localparam logic [15:0] MAGIC_BM   = 16'h4D42;
    localparam logic [15:0] BPP_24     = 16'd24;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [31:0]     r_pos, n_pos;
    logic [31:0]     r_shift, n_shift;
    logic [31:0]     r_info, n_info;
    logic [31:0]     r_offset, n_offset;
    logic [WW-1:0]   r_width, n_width;
    logic [HW-1:0]   r_height, n_height;
    logic            r_wbig, n_wbig;
    logic            r_hbig, n_hbig;
    logic [1:0]      r_row_pad, n_row_pad;
    logic [WW-1:0]   r_col, n_col;
    logic [HW-1:0]   r_row, n_row;
    logic [1:0]      r_color, n_color;
    logic [7:0]      r_first, n_first;
    logic [7:0]      r_second, n_second;
    logic [1:0]      r_pad, n_pad;

    t_phase          phase_cur;
    logic [31:0]     shift_base;
    logic [31:0]     pos_base;
    logic [31:0]     pos_inc;
    logic [31:0]     shift_new;
    logic            do_fail;
    t_err_code       fail_code;
    logic            do_finish;
    logic [5:0]      fin_end;
    logic [WW-1:0]   col_inc;
    logic            last_pix;
    logic [1:0]      pad_dec;
    logic [31:0]     col32;
    logic [31:0]     row32;
    t_result         res;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_shift   = r_shift;
        n_info    = r_info;
        n_offset  = r_offset;
        n_width   = r_width;
        n_height  = r_height;
        n_wbig    = r_wbig;
        n_hbig    = r_hbig;
        n_row_pad = r_row_pad;
        n_col     = r_col;
        n_row     = r_row;
        n_color   = r_color;
        n_first   = r_first;
        n_second  = r_second;
        n_pad     = r_pad;

        res            = '0;
        res.kind       = KIND_PIXEL;
        res.error_code = ERR_NONE;
        o_res_valid    = 1'b0;

        // A file start restarts parsing at byte zero
        phase_cur  = r_phase;
        shift_base = r_shift;
        pos_base   = r_pos;
        if (i_start_of_file) begin
            phase_cur  = PH_HEADER;
            shift_base = '0;
            pos_base   = '0;
        end

        pos_inc   = pos_base + 32'd1;
        shift_new = {i_data_byte, shift_base[31:8]};
        col_inc   = r_col + WW'(1);
        last_pix  = (r_row == r_height - HW'(1)) && (r_col == r_width - WW'(1));
        pad_dec   = (r_pad != 2'd0) ? r_pad - 2'd1 : 2'd0;
        col32     = 32'(r_col);
        row32     = 32'(r_row);

        do_fail   = 1'b0;
        fail_code = ERR_NONE;
        do_finish = 1'b0;
        fin_end   = HDR_END_EXT;

        if (i_fire) begin
            n_phase = phase_cur;
            n_shift = shift_base;
            n_pos   = pos_base;
            case (phase_cur)
                PH_HEADER: begin
                    n_shift = shift_new;
                    n_pos   = pos_inc;
                    case (pos_base)
                        POS_MAGIC: begin
                            if (shift_new[31:16] != MAGIC_BM) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_MAGIC;
                            end
                        end
                        POS_OFFSET: begin
                            n_offset = shift_new;
                        end
                        POS_INFO: begin
                            n_info = shift_new;
                            if (shift_new < 32'(i_core_min)) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_HEADER;
                            end
                        end
                        POS_WIDTH: begin
                            n_width   = shift_new[WW-1:0];
                            n_wbig    = shift_new > 32'(MAX_WIDTH);
                            n_row_pad = shift_new[1:0];
                        end
                        POS_HEIGHT: begin
                            n_height = shift_new[HW-1:0];
                            n_hbig   = shift_new > 32'(MAX_HEIGHT);
                        end
                        POS_BPP: begin
                            if (shift_new[31:16] != BPP_24) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_HEADER;
                            end else if (r_info < 32'(i_ext_min)) begin
                                do_finish = 1'b1;
                                fin_end   = HDR_END_CORE;
                            end
                        end
                        POS_COMP: begin
                            if (shift_new != 32'd0) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_COMPRESSED;
                            end
                        end
                        POS_END: begin
                            do_finish = 1'b1;
                            fin_end   = HDR_END_EXT;
                        end
                        default: ;
                    endcase
                end
                PH_SKIP: begin
                    // Advance until the byte before the pixel offset
                    n_pos = pos_inc;
                    if (pos_inc == r_offset) begin
                        n_phase = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    case (r_color)
                        2'd0: begin
                            n_first = i_data_byte;
                            n_color = 2'd1;
                        end
                        2'd1: begin
                            n_second = i_data_byte;
                            n_color  = 2'd2;
                        end
                        default: begin
                            // Emit one pixel and step the position
                            o_res_valid      = 1'b1;
                            res.first_color  = r_first;
                            res.second_color = r_second;
                            res.third_color  = i_data_byte;
                            res.pixel_column = col32[11:0];
                            res.pixel_row    = row32[11:0];
                            res.last_pixel   = last_pix;
                            n_color = 2'd0;
                            n_col   = col_inc;
                            if (col_inc == r_width) begin
                                n_col = '0;
                                n_row = r_row + HW'(1);
                                if (last_pix) begin
                                    n_phase = PH_WAIT;
                                end else if (r_row_pad != 2'd0) begin
                                    n_pad   = r_row_pad;
                                    n_phase = PH_PAD;
                                end
                            end
                        end
                    endcase
                end
                PH_PAD: begin
                    // Drop row padding
                    n_pad = pad_dec;
                    if (pad_dec == 2'd0) begin
                        n_phase = PH_PIXELS;
                    end
                end
                default: ;
            endcase

            // Report a failed check, or close the header: range checks, then pick skip, pixels or wait
            if (do_fail) begin
                o_res_valid    = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = fail_code;
                n_phase        = PH_WAIT;
            end else if (do_finish) begin
                if (r_offset < 32'(fin_end) || r_wbig || r_hbig) begin
                    o_res_valid    = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_RANGE;
                    n_phase        = PH_WAIT;
                end else if (r_width == '0 || r_height == '0) begin
                    n_phase = PH_WAIT;
                end else begin
                    n_col   = '0;
                    n_row   = '0;
                    n_color = 2'd0;
                    n_phase = (r_offset == 32'(fin_end)) ? PH_PIXELS : PH_SKIP;
                end
            end
        end

        o_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_pos   <= '0;
            r_shift <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_shift <= n_shift;
        end
        r_info    <= n_info;
        r_offset  <= n_offset;
        r_width   <= n_width;
        r_height  <= n_height;
        r_wbig    <= n_wbig;
        r_hbig    <= n_hbig;
        r_row_pad <= n_row_pad;
        r_col     <= n_col;
        r_row     <= n_row;
        r_color   <= n_color;
        r_first   <= n_first;
        r_second  <= n_second;
        r_pad     <= n_pad;
    end

endmodule

[src/bmpd_out_fifo.sv]
// Two-entry result buffer of the BMP stream decoder.
// Depends on bmpd_pkg for the result word type.
module bmpd_out_fifo
    import bmpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_valid,
    input  t_result i_wr_data,
    output logic    o_wr_ready,
    output logic    o_rd_valid,
    output t_result o_rd_data,
    input  logic    i_rd_ready
);

    t_result    r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    // Store incoming words
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/bmp24_stream_decoder_unit.sv]
// Top level of the streaming decoder for uncompressed 24-bit BMP files.
// Depends on bmpd_pkg, bmpd_in_reg, bmpd_parse and bmpd_out_fifo.
//
// The decoder takes one file byte per cycle, with no gaps needed between
// files, as long as the receiver keeps taking results. A byte is held in
// the input register; its result, if any, is written from there into a
// two-entry output buffer, which presents it on the output. The throughput
// of one byte per cycle is set by the single parse step between the input
// register and the output buffer; while the buffer is full the byte waits
// in the input register and the input stalls until a result word leaves.
// Errors are reported once per file, then bytes are ignored until the
// next start_of_file. Configuration writes are always taken (cfg ready
// is tied high) and should be made while idle.
module bmp24_stream_decoder_unit
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_start_of_file,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_result_kind,
    output logic [2:0]           o_error_code,
    output logic [7:0]           o_first_color,
    output logic [7:0]           o_second_color,
    output logic [7:0]           o_third_color,
    output logic [11:0]          o_pixel_column,
    output logic [11:0]          o_pixel_row,
    output logic                 o_last_pixel,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic [7:0] r_core_min_val;
    logic [7:0] r_ext_min_val;
    logic       st_valid;
    logic [7:0] st_byte;
    logic       st_start;
    logic       buf_ready;
    logic       res_valid;
    t_result    res;
    t_result    out_word;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_min_val <= CORE_MIN_RST;
            r_ext_min_val  <= EXT_MIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CORE_MIN: r_core_min_val <= i_cfg_data;
                CFG_EXT_MIN:  r_ext_min_val  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bmpd_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_down_ready    (buf_ready),
        .o_valid         (st_valid),
        .o_data_byte     (st_byte),
        .o_start_of_file (st_start)
    );

    bmpd_parse #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (st_valid && buf_ready),
        .i_data_byte     (st_byte),
        .i_start_of_file (st_start),
        .i_core_min      (r_core_min_val),
        .i_ext_min       (r_ext_min_val),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    bmpd_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (res_valid),
        .i_wr_data  (res),
        .o_wr_ready (buf_ready),
        .o_rd_valid (o_valid),
        .o_rd_data  (out_word),
        .i_rd_ready (i_ready)
    );

    // Unpack the result word
    assign o_result_kind  = out_word.kind;
    assign o_error_code   = out_word.error_code;
    assign o_first_color  = out_word.first_color;
    assign o_second_color = out_word.second_color;
    assign o_third_color  = out_word.third_color;
    assign o_pixel_column = out_word.pixel_column;
    assign o_pixel_row    = out_word.pixel_row;
    assign o_last_pixel   = out_word.last_pixel;

endmodule

[src/bmpd_checker.sv]
// Port-level checks of the BMP stream decoder, bound to the top level.
// Depends on bmpd_pkg and on the port names of bmp24_stream_decoder_unit.
module bmpd_checker
    import bmpd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_result_kind,
    input logic [2:0]  o_error_code,
    input logic [7:0]  o_first_color,
    input logic [7:0]  o_second_color,
    input logic [7:0]  o_third_color,
    input logic [11:0] o_pixel_column,
    input logic [11:0] o_pixel_row,
    input logic        o_last_pixel
);

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_kind)
            && $stable(o_error_code) && $stable(o_first_color)
            && $stable(o_second_color) && $stable(o_third_color)
            && $stable(o_pixel_column) && $stable(o_pixel_row)
            && $stable(o_last_pixel))
        else $error("result word changed while stalled");

    // Error words carry a code and no pixel data
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_ERROR) |->
            (o_error_code != ERR_NONE) && (o_first_color == 8'd0)
            && (o_second_color == 8'd0) && (o_third_color == 8'd0)
            && (o_pixel_column == 12'd0) && (o_pixel_row == 12'd0)
            && !o_last_pixel)
        else $error("malformed error word");

    // Pixel words carry no error code
    a_pixel_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_PIXEL) |-> (o_error_code == ERR_NONE))
        else $error("pixel word with error code");

endmodule

bind bmp24_stream_decoder_unit bmpd_checker u_bmpd_checker (.*);
